// ----- hw/rtl/sky_pkg.sv -----
// Shared types and constants for the skyline atlas allocator.
// Used by sky_winmax and skyline_atlas_allocator; depends on nothing.
package sky_pkg;

    localparam int BLOCKS_W = 10;
    localparam int POS_W    = 9;
    localparam int PAGE_W   = 6;

    typedef enum logic [1:0] {
        STAT_PLACED    = 2'd0,
        STAT_NEW_PAGE  = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_EXHAUSTED = 2'd3
    } sky_status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_PASS1,
        FSM_PASS2,
        FSM_DECIDE,
        FSM_WRITE,
        FSM_DONE
    } sky_state_t;

    // Per-cycle controls of the window maximum datapath.
    typedef struct packed {
        logic init;
        logic p1_vld;
        logic p2_vld;
        logic win_vld;
    } scan_ctl_t;

endpackage

// ----- hw/rtl/sky_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; no package dependencies.
module sky_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sky_winmax.sv -----
// Sliding window maximum over the skyline, split into blocks of the request width.
// Pass 1 builds suffix maxima per block, pass 2 prefix maxima and tracks the best window.
// Depends on sky_pkg.
module sky_winmax #(
    parameter int ATLAS_SIZE = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sky_pkg::scan_ctl_t                 ctl,
    input  logic [$clog2(ATLAS_SIZE)-1:0]      wm1,
    input  logic [$clog2(ATLAS_SIZE)-1:0]      win_x,
    input  logic [$clog2(ATLAS_SIZE+1)-1:0]    col_data,
    input  logic [$clog2(ATLAS_SIZE+1)-1:0]    g_data,
    output logic [$clog2(ATLAS_SIZE+1)-1:0]    g_wdata,
    output logic [$clog2(ATLAS_SIZE+1)-1:0]    best,
    output logic [$clog2(ATLAS_SIZE)-1:0]      best_x
);

    localparam int AW = $clog2(ATLAS_SIZE);
    localparam int HW = $clog2(ATLAS_SIZE + 1);

    logic          p1_new_reg;
    logic          p2_new_reg;
    logic          p2_first_reg;
    logic [AW-1:0] p1_pos_reg;
    logic [AW-1:0] p0_reg;
    logic [AW-1:0] p2_cd_reg;
    logic [AW-1:0] p2_cd_next;
    logic [HW-1:0] p1_run_reg;
    logic [HW-1:0] p2_run_reg;
    logic [HW-1:0] p2_run_next;
    logic [HW-1:0] win_max;
    logic [HW-1:0] best_reg;
    logic [AW-1:0] best_x_reg;

    always_comb
    begin
        // Pass 1 walks right to left, so a new block starts at its right end.
        if (p1_new_reg || (col_data > p1_run_reg))
        begin
            g_wdata = col_data;
        end
        else
        begin
            g_wdata = p1_run_reg;
        end

        if (p2_new_reg || (col_data > p2_run_reg))
        begin
            p2_run_next = col_data;
        end
        else
        begin
            p2_run_next = p2_run_reg;
        end

        // The leftmost block may be partial; its length comes from pass 1.
        if (p2_new_reg)
        begin
            p2_cd_next = p2_first_reg ? p0_reg : wm1;
        end
        else
        begin
            p2_cd_next = p2_cd_reg - 1'b1;
        end

        win_max = (g_data > p2_run_next) ? g_data : p2_run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_new_reg   <= 1'b1;
            p2_new_reg   <= 1'b1;
            p2_first_reg <= 1'b1;
            p1_pos_reg   <= '0;
        end
        else if (ctl.init)
        begin
            p1_new_reg   <= 1'b1;
            p2_new_reg   <= 1'b1;
            p2_first_reg <= 1'b1;
            p1_pos_reg   <= '0;
        end
        else
        begin
            if (ctl.p1_vld)
            begin
                if (p1_pos_reg == wm1)
                begin
                    p1_pos_reg <= '0;
                    p1_new_reg <= 1'b1;
                end
                else
                begin
                    p1_pos_reg <= p1_pos_reg + 1'b1;
                    p1_new_reg <= 1'b0;
                end
            end
            if (ctl.p2_vld)
            begin
                p2_new_reg   <= (p2_cd_next == '0);
                p2_first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            best_reg   <= HW'(ATLAS_SIZE);
            best_x_reg <= '0;
        end
        else
        begin
            if (ctl.p1_vld)
            begin
                p1_run_reg <= g_wdata;
                p0_reg     <= p1_pos_reg;
            end
            if (ctl.p2_vld)
            begin
                p2_run_reg <= p2_run_next;
                p2_cd_reg  <= p2_cd_next;
                if (ctl.win_vld && (win_max < best_reg))
                begin
                    best_reg   <= win_max;
                    best_x_reg <= win_x;
                end
            end
        end
    end

    assign best   = best_reg;
    assign best_x = best_x_reg;

endmodule

// ----- hw/rtl/skyline_atlas_allocator.sv -----
// Each request runs pass 1, pass 2 and a decision, then column writes across w columns
// for a placement on the current page or across all ATLAS_SIZE for one on a fresh page; a request that
// cannot be placed skips the writes, and a zero width or one of ATLAS_SIZE or more skips pass 2.
// Throughput: one request in flight; the next is taken once the result has issued.
// Reset: asynchronous, active low; then a clearing pass zeroes the column memory,
// during which requests are stalled.
module skyline_atlas_allocator #(
    parameter int ATLAS_SIZE = 512,
    parameter int MAX_PAGES  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [sky_pkg::BLOCKS_W-1:0]  width_blocks,
    input  logic [sky_pkg::BLOCKS_W-1:0]  height_blocks,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sky_pkg::POS_W-1:0]     pos_x,
    output logic [sky_pkg::POS_W-1:0]     pos_y,
    output logic [sky_pkg::PAGE_W-1:0]    page_index,
    output logic [1:0]                    status
);

    localparam int AW = $clog2(ATLAS_SIZE);
    localparam int HW = $clog2(ATLAS_SIZE + 1);
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = (AW + 1 > sky_pkg::BLOCKS_W + 1) ? AW + 1 : sky_pkg::BLOCKS_W + 1;
    localparam int SW = (HW > sky_pkg::BLOCKS_W) ? HW + 1 : sky_pkg::BLOCKS_W + 1;

    sky_pkg::sky_state_t state_reg;
    sky_pkg::sky_state_t state_next;

    logic [AW:0]                   cnt_reg;
    logic [AW:0]                   cnt_next;
    logic [sky_pkg::BLOCKS_W-1:0]  w_reg;
    logic [sky_pkg::BLOCKS_W-1:0]  h_reg;
    logic                          rd_p1_reg;
    logic                          rd_p2_reg;
    logic                          rd_win_reg;
    logic [AW-1:0]                 rd_addr_reg;
    logic [AW-1:0]                 rd_x_reg;
    logic [PW-1:0]                 page_reg;
    logic [AW-1:0]                 wr_base_reg;
    logic [AW-1:0]                 wr_last_reg;
    logic [HW-1:0]                 wr_val_reg;
    logic [sky_pkg::POS_W-1:0]     hold_x_reg;
    logic [sky_pkg::POS_W-1:0]     hold_y_reg;
    sky_pkg::sky_status_t          hold_st_reg;
    logic                          res_valid_reg;
    logic [sky_pkg::POS_W-1:0]     res_x_reg;
    logic [sky_pkg::POS_W-1:0]     res_y_reg;
    logic [sky_pkg::PAGE_W-1:0]    res_page_reg;
    sky_pkg::sky_status_t          res_st_reg;

    logic                          accept;
    logic                          w_ok;
    logic                          fit;
    logic                          last_page;
    logic                          h_big;
    logic                          out_free;
    logic [AW-1:0]                 wm1;
    logic [SW-1:0]                 top_sum;
    logic                          iss_p1;
    logic                          iss_p2;
    logic                          iss_win;
    logic                          col_we;
    logic [AW-1:0]                 col_waddr;
    logic [HW-1:0]                 col_wdata;
    logic [AW-1:0]                 col_raddr;
    logic [HW-1:0]                 col_rdata;
    logic [AW-1:0]                 g_raddr;
    logic [HW-1:0]                 g_rdata;
    logic [HW-1:0]                 g_wdata;
    logic [HW-1:0]                 best;
    logic [AW-1:0]                 best_x;
    sky_pkg::scan_ctl_t            scan_ctl;

    assign accept    = req_valid && !req_stall;
    assign w_ok      = (w_reg != '0) && (CW'(w_reg) < CW'(ATLAS_SIZE));
    assign wm1       = AW'(w_reg - 1'b1);
    assign top_sum   = SW'(best) + SW'(h_reg);
    assign fit       = w_ok && (top_sum <= SW'(ATLAS_SIZE));
    assign last_page = (page_reg == PW'(MAX_PAGES - 1));
    assign h_big     = SW'(h_reg) > SW'(ATLAS_SIZE);
    assign out_free  = !res_valid_reg || !res_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sky_pkg::FSM_CLEAR:
            begin
                if (cnt_reg[AW-1:0] == AW'(ATLAS_SIZE - 1))
                begin
                    state_next = sky_pkg::FSM_IDLE;
                end
            end
            sky_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = sky_pkg::FSM_PASS1;
                end
            end
            sky_pkg::FSM_PASS1:
            begin
                if (!w_ok)
                begin
                    state_next = sky_pkg::FSM_DECIDE;
                end
                else if (cnt_reg == (AW + 1)'(ATLAS_SIZE))
                begin
                    state_next = sky_pkg::FSM_PASS2;
                end
            end
            sky_pkg::FSM_PASS2:
            begin
                if (cnt_reg == (AW + 1)'(ATLAS_SIZE - 1))
                begin
                    state_next = sky_pkg::FSM_DECIDE;
                end
            end
            sky_pkg::FSM_DECIDE:
            begin
                if (fit)
                begin
                    state_next = sky_pkg::FSM_WRITE;
                end
                else if (last_page || !w_ok || h_big)
                begin
                    state_next = sky_pkg::FSM_DONE;
                end
                else
                begin
                    state_next = sky_pkg::FSM_WRITE;
                end
            end
            sky_pkg::FSM_WRITE:
            begin
                if (cnt_reg[AW-1:0] == wr_last_reg)
                begin
                    state_next = sky_pkg::FSM_DONE;
                end
            end
            sky_pkg::FSM_DONE:
            begin
                if (out_free)
                begin
                    state_next = sky_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = sky_pkg::FSM_IDLE;
            end
        endcase
    end

    // State outputs: memory ports, read issue and request stall.
    always_comb
    begin
        req_stall = 1'b1;
        col_we    = 1'b0;
        col_waddr = cnt_reg[AW-1:0];
        col_wdata = '0;
        col_raddr = cnt_reg[AW-1:0];
        g_raddr   = cnt_reg[AW-1:0] - wm1;
        iss_p1    = 1'b0;
        iss_p2    = 1'b0;
        iss_win   = 1'b0;
        case (state_reg)
            sky_pkg::FSM_CLEAR:
            begin
                col_we = 1'b1;
            end
            sky_pkg::FSM_IDLE:
            begin
                req_stall = 1'b0;
            end
            sky_pkg::FSM_PASS1:
            begin
                col_raddr = AW'(ATLAS_SIZE - 1) - cnt_reg[AW-1:0];
                iss_p1    = w_ok && (cnt_reg < (AW + 1)'(ATLAS_SIZE));
            end
            sky_pkg::FSM_PASS2:
            begin
                iss_p2  = cnt_reg < (AW + 1)'(ATLAS_SIZE - 1);
                iss_win = cnt_reg >= (AW + 1)'(wm1);
            end
            sky_pkg::FSM_WRITE:
            begin
                col_we    = 1'b1;
                col_waddr = wr_base_reg + cnt_reg[AW-1:0];
                // On a fresh page the sweep clears every column past the rectangle.
                col_wdata = (CW'(cnt_reg) < CW'(w_reg)) ? wr_val_reg : '0;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sky_pkg::FSM_CLEAR;
            cnt_reg       <= '0;
            rd_p1_reg     <= 1'b0;
            rd_p2_reg     <= 1'b0;
            rd_win_reg    <= 1'b0;
            page_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_p1_reg  <= iss_p1;
            rd_p2_reg  <= iss_p2;
            rd_win_reg <= iss_win;
            if ((state_reg == sky_pkg::FSM_DECIDE) && !fit && !last_page && w_ok && !h_big)
            begin
                page_reg <= page_reg + 1'b1;
            end
            if ((state_reg == sky_pkg::FSM_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg <= width_blocks;
            h_reg <= height_blocks;
        end
        rd_addr_reg <= col_raddr;
        rd_x_reg    <= cnt_reg[AW-1:0] - wm1;
        if (state_reg == sky_pkg::FSM_DECIDE)
        begin
            if (fit)
            begin
                hold_x_reg  <= sky_pkg::POS_W'(best_x);
                hold_y_reg  <= sky_pkg::POS_W'(best);
                hold_st_reg <= sky_pkg::STAT_PLACED;
                wr_base_reg <= best_x;
                wr_val_reg  <= HW'(top_sum);
                wr_last_reg <= wm1;
            end
            else
            begin
                hold_x_reg  <= '0;
                hold_y_reg  <= '0;
                wr_base_reg <= '0;
                wr_val_reg  <= HW'(h_reg);
                wr_last_reg <= AW'(ATLAS_SIZE - 1);
                if (last_page)
                begin
                    hold_st_reg <= sky_pkg::STAT_EXHAUSTED;
                end
                else if (!w_ok || h_big)
                begin
                    hold_st_reg <= sky_pkg::STAT_TOO_LARGE;
                end
                else
                begin
                    hold_st_reg <= sky_pkg::STAT_NEW_PAGE;
                end
            end
        end
        if ((state_reg == sky_pkg::FSM_DONE) && out_free)
        begin
            res_x_reg    <= hold_x_reg;
            res_y_reg    <= hold_y_reg;
            res_page_reg <= sky_pkg::PAGE_W'(page_reg);
            res_st_reg   <= hold_st_reg;
        end
    end

    assign scan_ctl.init    = accept;
    assign scan_ctl.p1_vld  = rd_p1_reg;
    assign scan_ctl.p2_vld  = rd_p2_reg;
    assign scan_ctl.win_vld = rd_win_reg;

    sky_ram #(
        .WIDTH (HW),
        .DEPTH (ATLAS_SIZE)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // Holds the per-block suffix maxima from pass 1.
    sky_ram #(
        .WIDTH (HW),
        .DEPTH (ATLAS_SIZE)
    ) u_sfx_ram (
        .clk   (clk),
        .we    (rd_p1_reg),
        .waddr (rd_addr_reg),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    sky_winmax #(
        .ATLAS_SIZE (ATLAS_SIZE)
    ) u_winmax (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .wm1      (wm1),
        .win_x    (rd_x_reg),
        .col_data (col_rdata),
        .g_data   (g_rdata),
        .g_wdata  (g_wdata),
        .best     (best),
        .best_x   (best_x)
    );

    assign res_valid  = res_valid_reg;
    assign pos_x      = res_x_reg;
    assign pos_y      = res_y_reg;
    assign page_index = res_page_reg;
    assign status     = res_st_reg;

`ifndef ASSERT_OFF
    // Column writes never collide with a scan read still in flight.
    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        col_we |-> !(rd_p1_reg || rd_p2_reg))
        else $error("column write overlaps a pending scan read");

    // Error results carry a zero position.
    a_error_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((status == sky_pkg::STAT_TOO_LARGE) ||
                       (status == sky_pkg::STAT_EXHAUSTED)))
        |-> ((pos_x == '0) && (pos_y == '0)))
        else $error("error result with nonzero position");

    // The page only advances out of the decision step.
    a_page_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(page_reg) |-> ($past(state_reg) == sky_pkg::FSM_DECIDE))
        else $error("page changed outside the decision step");
`endif

endmodule

// ----- bench/tb_skyline_atlas_allocator.sv -----
// Self-checking bench for skyline_atlas_allocator: directed rows, then randomized requests
// checked against an in-bench skyline placement predictor. Depends on sky_pkg and the RTL.
module tb_skyline_atlas_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE          = 512;
    localparam int PAGES         = 64;
    localparam int N_DIR         = 24;
    localparam int N_RANDOM      = 576;
    localparam int DRAIN_CYCLES  = 3 * SIZE + 16;
    localparam int HOLD_AT       = 50000;
    localparam int HOLD_CYCLES   = 4000;
    localparam longint LIMIT_CYCLES = 10000000;

    typedef struct packed {
        logic [sky_pkg::POS_W-1:0]  x;
        logic [sky_pkg::POS_W-1:0]  y;
        logic [sky_pkg::PAGE_W-1:0] page;
        sky_pkg::sky_status_t       st;
    } placement_t;

    typedef struct packed {
        logic [sky_pkg::BLOCKS_W-1:0] w;
        logic [sky_pkg::BLOCKS_W-1:0] h;
        logic                         typed;
        placement_t                   want;
    } dir_row_t;

    localparam placement_t NO_WANT = '0;

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{10'd1,    10'd1,    1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_PLACED}},
        '{10'd0,    10'd7,    1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_TOO_LARGE}},
        '{10'd512,  10'd1,    1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_TOO_LARGE}},
        '{10'd1023, 10'd1023, 1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_TOO_LARGE}},
        '{10'd10,   10'd513,  1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_TOO_LARGE}},
        '{10'd1,    10'd1023, 1'b1, '{9'd0, 9'd0, 6'd0, sky_pkg::STAT_TOO_LARGE}},
        '{10'd5,    10'd0,    1'b0, NO_WANT},
        '{10'd4,    10'd7,    1'b0, NO_WANT},
        '{10'd4,    10'd7,    1'b0, NO_WANT},
        '{10'd3,    10'd2,    1'b0, NO_WANT},
        '{10'd511,  10'd1,    1'b0, NO_WANT},
        '{10'd1,    10'd512,  1'b0, NO_WANT},
        '{10'd511,  10'd512,  1'b0, NO_WANT},
        // Every window is full here, so a zero-height request lands at a row that wraps.
        '{10'd1,    10'd0,    1'b0, NO_WANT},
        '{10'd1,    10'd1,    1'b0, NO_WANT},
        '{10'd1,    10'd512,  1'b0, NO_WANT},
        '{10'd256,  10'd256,  1'b0, NO_WANT},
        '{10'd256,  10'd256,  1'b0, NO_WANT},
        '{10'd256,  10'd1,    1'b0, NO_WANT},
        '{10'd511,  10'd0,    1'b0, NO_WANT},
        '{10'd2,    10'd1023, 1'b0, NO_WANT},
        '{10'd1022, 10'd0,    1'b0, NO_WANT},
        '{10'd682,  10'd341,  1'b0, NO_WANT},
        '{10'd341,  10'd170,  1'b0, NO_WANT}
    };

    localparam logic [sky_pkg::BLOCKS_W-1:0] EDGE_W [5] =
        '{10'd0, 10'd1, 10'd511, 10'd512, 10'd1023};
    localparam logic [sky_pkg::BLOCKS_W-1:0] EDGE_H [5] =
        '{10'd0, 10'd1, 10'd512, 10'd513, 10'd1023};

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_stall;
    logic [sky_pkg::BLOCKS_W-1:0] width_blocks;
    logic [sky_pkg::BLOCKS_W-1:0] height_blocks;
    logic                         res_valid;
    logic                         res_stall;
    logic [sky_pkg::POS_W-1:0]    pos_x;
    logic [sky_pkg::POS_W-1:0]    pos_y;
    logic [sky_pkg::PAGE_W-1:0]   page_index;
    logic [1:0]                   status;

    // Predictor state: the skyline of the page being filled and its index.
    logic [sky_pkg::BLOCKS_W-1:0] skyline_h [SIZE];
    int unsigned                  cur_page;

    placement_t placements_q [$];
    int         mismatches = 0;
    int         sent_count = 0;
    int         burst_left = 0;

    skyline_atlas_allocator #(
        .ATLAS_SIZE (SIZE),
        .MAX_PAGES  (PAGES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .width_blocks  (width_blocks),
        .height_blocks (height_blocks),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .page_index    (page_index),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Places one rectangle on the predicted skyline and returns the expected result.
    function automatic placement_t place_rect(input int unsigned w, input int unsigned h);
        placement_t  r;
        int unsigned best;
        int unsigned bx;
        int unsigned top;
        int unsigned c;
        int unsigned x;
        int unsigned k;
        bit          fits;
        best = SIZE;
        bx   = 0;
        fits = 1'b0;
        if (w != 0 && w < SIZE)
        begin
            // The last left column, SIZE-w, is never tried.
            for (x = 0; x < SIZE - w; x++)
            begin
                top = 0;
                for (k = 0; k < w; k++)
                begin
                    c = 32'(skyline_h[x + k]);
                    if (c >= best)
                        break;
                    if (c > top)
                        top = c;
                end
                if (k == w)
                begin
                    best = top;
                    bx   = x;
                end
            end
            fits = (best + h <= SIZE);
        end
        if (fits)
            r.st = sky_pkg::STAT_PLACED;
        else if (cur_page + 1 >= PAGES)
            r.st = sky_pkg::STAT_EXHAUSTED;
        else if (w == 0 || w >= SIZE || h > SIZE)
            r.st = sky_pkg::STAT_TOO_LARGE;
        else
        begin
            for (k = 0; k < SIZE; k++)
                skyline_h[k] = '0;
            cur_page++;
            bx   = 0;
            best = 0;
            r.st = sky_pkg::STAT_NEW_PAGE;
        end
        if (r.st == sky_pkg::STAT_PLACED || r.st == sky_pkg::STAT_NEW_PAGE)
        begin
            for (k = 0; k < w && bx + k < SIZE; k++)
                skyline_h[bx + k] = sky_pkg::BLOCKS_W'(best + h);
        end
        else
        begin
            bx   = 0;
            best = 0;
        end
        r.x    = sky_pkg::POS_W'(bx);
        r.y    = sky_pkg::POS_W'(best);
        r.page = sky_pkg::PAGE_W'(cur_page);
        return r;
    endfunction

    // Paces the sender, offers one request, and queues its expected result once accepted.
    task automatic offer_request(input logic [sky_pkg::BLOCKS_W-1:0] w,
                                 input logic [sky_pkg::BLOCKS_W-1:0] h,
                                 input logic typed, input placement_t want);
        placement_t got;
        int         gap;
        if (sent_count != 0)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 7);
                case ($urandom_range(0, 7))
                    0: gap = $urandom_range(300, 1600);
                    1, 2: gap = 0;
                    default: gap = $urandom_range(1, 12);
                endcase
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        req_valid     <= 1'b1;
        width_blocks  <= w;
        height_blocks <= h;
        do @(posedge clk); while (req_stall !== 1'b0);
        got = place_rect(32'(w), 32'(h));
        placements_q.push_back(typed ? want : got);
        sent_count++;
    endtask

    initial
    begin
        logic [sky_pkg::BLOCKS_W-1:0] w;
        logic [sky_pkg::BLOCKS_W-1:0] h;
        int unsigned                  target;
        int unsigned                  pick;
        for (int k = 0; k < SIZE; k++)
            skyline_h[k] = '0;
        cur_page      = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        width_blocks  = '0;
        height_blocks = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            offer_request(DIR_TAB[i].w, DIR_TAB[i].h, DIR_TAB[i].typed, DIR_TAB[i].want);

        // Large rectangles are mixed in so the page count climbs steadily and the
        // last pages run out near the end of the random part.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            target = (i * 72) / N_RANDOM;
            pick   = $urandom_range(0, 99);
            if (pick < 5)
            begin
                w = sky_pkg::BLOCKS_W'($urandom_range(0, 1023));
                h = sky_pkg::BLOCKS_W'($urandom_range(0, 1023));
            end
            else if (pick < 9)
            begin
                w = EDGE_W[$urandom_range(0, 4)];
                h = EDGE_H[$urandom_range(0, 4)];
            end
            else if (cur_page < target && pick < 60)
            begin
                w = sky_pkg::BLOCKS_W'($urandom_range(200, 511));
                h = sky_pkg::BLOCKS_W'($urandom_range(300, 512));
            end
            else
            begin
                w = sky_pkg::BLOCKS_W'($urandom_range(1, 40));
                h = sky_pkg::BLOCKS_W'($urandom_range(0, 40));
            end
            offer_request(w, h, 1'b0, NO_WANT);
        end
        req_valid <= 1'b0;

        while (placements_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: segments of differing stall density, and one long hold-off so the
    // allocator backs up and stalls new requests.
    initial
    begin
        int     seg;
        int     kind;
        longint cyc;
        bit     held;
        res_stall = 1'b0;
        cyc       = 0;
        held      = 1'b0;
        forever
        begin
            seg  = $urandom_range(20, 600);
            kind = $urandom_range(0, 3);
            repeat (seg)
            begin
                @(posedge clk);
                cyc++;
                if (!held && cyc >= HOLD_AT)
                begin
                    held = 1'b1;
                    res_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    cyc += HOLD_CYCLES;
                end
                case (kind)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 7) == 0);
                    2: res_stall <= 1'($urandom_range(0, 1));
                    default: res_stall <= ((cyc % 16) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (placements_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d page=%0d status=%0d",
                             pos_x, pos_y, page_index, status);
            end
            else
            begin
                want = placements_q.pop_front();
                if (pos_x !== want.x || pos_y !== want.y || page_index !== want.page
                    || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected x=%0d y=%0d page=%0d status=%0d, %s",
                                 want.x, want.y, want.page, want.st,
                                 $sformatf("got x=%0d y=%0d page=%0d status=%0d",
                                           pos_x, pos_y, page_index, status));
                end
            end
        end
    end

    initial
    begin
        longint cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
